// ===== sv/swstat_pkg.sv =====
// ---------------------------------------------------------------------------
// swstat_pkg: shared types and constants for the window statistics core
// Sample widths, the saturation limit and the stream word layout.
// ---------------------------------------------------------------------------
package swstat_pkg;

    localparam int SAMPLE_W      = 14;
    localparam int OUT_COUNT_W   = 7;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT = 14'd10000;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;

    // one store word holds both readings of a sample
    typedef struct packed {
        logic [SAMPLE_W-1:0] co2;
        logic [SAMPLE_W-1:0] pm25;
    } sample_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic                   pad;
        logic [SAMPLE_W-1:0]    pm25_mean;
        logic [SAMPLE_W-1:0]    pm25_maximum;
        logic [SAMPLE_W-1:0]    pm25_minimum;
        logic [SAMPLE_W-1:0]    co2_mean;
        logic [OUT_COUNT_W-1:0] stored_count;
    } result_t;

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [SAMPLE_W-1:0] v);
        clamp_sample = (v > SAMPLE_LIMIT) ? SAMPLE_LIMIT : v;
    endfunction

endpackage

// ===== sv/swstat_store.sv =====
// ---------------------------------------------------------------------------
// swstat_store: ring store of recent samples
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module swstat_store
    import swstat_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEFAULT,
    parameter int ADDR_W       = $clog2(WINDOW_DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  sample_t           wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output sample_t           rd_data
);

    sample_t mem [WINDOW_DEPTH];
    sample_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/swstat_div.sv =====
// ---------------------------------------------------------------------------
// swstat_div: serial restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ---------------------------------------------------------------------------
module swstat_div
    import swstat_pkg::*;
#(
    parameter int SUM_W = 21,
    parameter int CNT_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg,  quo_next;
    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [CNT_W-1:0]  div_reg,  div_next;
    logic [CNT_W:0]    trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, div_reg}) begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/sensor_window_statistics_core.sv =====
// ---------------------------------------------------------------------------
// sensor_window_statistics_core: sliding window min, max and mean
// Stores air-quality samples in a ring of WINDOW_DEPTH entries and reports
// count, mean CO2 and min/max/mean PM2.5 over the stored samples.
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata fields (lsb first)                     | per request
//  --------+-----+----------------------------------------------+------------
//  s_      | in  | pm25_sample[13:0], co2_sample[27:14], 0 pad  | one sample
//  m_      | out | stored_count[6:0], co2_mean[20:7],           | one result
//          |     | pm25_minimum[34:21], pm25_maximum[48:35],    |
//          |     | pm25_mean[62:49], 0 pad                      |
//
// Sequence: a request scans the N samples held (up to WINDOW_DEPTH), and
//   SUM_W = 14 + clog2(depth + 1) is the width of the sums. The scan reads
//   one store entry per cycle, then one serial divider forms both means
//   in turn.
// s_tready is high only in idle; a finished result parks in the m_ register
//   so the next sample can be taken while it waits.
// A new result waits in its final state until the m_ register is free.
// Reset (aresetn low, synchronous) clears pointer, fill count and control;
//   the store has no clearing pass, only written entries are ever read.
//
module sensor_window_statistics_core
    import swstat_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pm25_sample[13:0], co2_sample[27:14]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // count, co2_mean, pm25 min, max, mean
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_DIV_CO2 = 3'd2;
    localparam logic [2:0] ST_DIV_PM  = 3'd3;
    localparam logic [2:0] ST_OUT     = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [SUM_W-1:0]    pm_sum_reg, pm_sum_next;
    logic [SUM_W-1:0]    co2_sum_reg, co2_sum_next;
    logic [SAMPLE_W-1:0] pm_min_reg, pm_min_next;
    logic [SAMPLE_W-1:0] pm_max_reg, pm_max_next;
    logic [SAMPLE_W-1:0] co2_mean_reg, co2_mean_next;
    logic [SAMPLE_W-1:0] pm_mean_reg, pm_mean_next;
    result_t             m_data_reg, m_data_next;

    logic                s_accept;
    logic                rd_issue;
    sample_t             wr_sample;
    sample_t             rd_sample;
    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic                div_done;
    logic [SUM_W-1:0]    div_quotient;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // saturate both readings before they reach the store
    assign wr_sample.pm25 = clamp_sample(s_tdata[SAMPLE_W-1:0]);
    assign wr_sample.co2  = clamp_sample(s_tdata[2*SAMPLE_W-1:SAMPLE_W]);

    // scan issues one read per cycle over entries 0 .. fill-1
    assign rd_issue = (state_reg == ST_SCAN) && (idx_reg < fill_reg);

    swstat_store #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_sample),
        .rd_en   (rd_issue),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_sample)
    );

    swstat_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        rd_vld_next   = rd_issue;
        m_tvalid_next = m_tvalid_reg;
        pm_sum_next   = pm_sum_reg;
        co2_sum_next  = co2_sum_reg;
        pm_min_next   = pm_min_reg;
        pm_max_next   = pm_max_reg;
        co2_mean_next = co2_mean_reg;
        pm_mean_next  = pm_mean_reg;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        div_dividend  = co2_sum_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // fold the entry read last cycle into the running stats
        if (rd_vld_reg) begin
            pm_sum_next  = pm_sum_reg + SUM_W'(rd_sample.pm25);
            co2_sum_next = co2_sum_reg + SUM_W'(rd_sample.co2);
            if (rd_sample.pm25 < pm_min_reg) pm_min_next = rd_sample.pm25;
            if (rd_sample.pm25 > pm_max_reg) pm_max_next = rd_sample.pm25;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
                    if (fill_reg != FULL_CNT) fill_next = fill_reg + 1'b1;
                    idx_next     = '0;
                    pm_sum_next  = '0;
                    co2_sum_next = '0;
                    pm_min_next  = '1;
                    pm_max_next  = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_issue) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!rd_vld_reg) begin
                    // sums are final; divide CO2 first
                    div_start  = 1'b1;
                    state_next = ST_DIV_CO2;
                end
            end
            ST_DIV_CO2: begin
                if (div_done) begin
                    co2_mean_next = div_quotient[SAMPLE_W-1:0];
                    div_start     = 1'b1;
                    div_dividend  = pm_sum_reg;
                    state_next    = ST_DIV_PM;
                end
            end
            ST_DIV_PM: begin
                // keep the mean aside; a parked result may still sit in m_
                if (div_done) begin
                    pm_mean_next = div_quotient[SAMPLE_W-1:0];
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_data_next.pad          = 1'b0;
                    m_data_next.stored_count = fill_reg[OUT_COUNT_W-1:0];
                    m_data_next.co2_mean     = co2_mean_reg;
                    m_data_next.pm25_minimum = pm_min_reg;
                    m_data_next.pm25_maximum = pm_max_reg;
                    m_data_next.pm25_mean    = pm_mean_reg;
                    m_tvalid_next            = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pm_sum_reg   <= pm_sum_next;
        co2_sum_reg  <= co2_sum_next;
        pm_min_reg   <= pm_min_next;
        pm_max_reg   <= pm_max_next;
        co2_mean_reg <= co2_mean_next;
        pm_mean_reg  <= pm_mean_next;
        m_data_reg   <= m_data_next;
    end

    // ---- assertions ----

    // an accepted sample always starts a scan
    a_accept_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_SCAN))
        else $error("accepted sample did not start a scan");

    // fill count saturates at the window depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("fill count above window depth");

    // until the ring wraps, the write pointer tracks the fill count
    a_ptr_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg < FULL_CNT) |-> (CNT_W'(wr_ptr_reg) == fill_reg))
        else $error("write pointer out of step with fill count");

    // a result has min <= mean <= max for PM2.5
    a_result_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_data_reg.pm25_minimum <= m_data_reg.pm25_mean &&
                          m_data_reg.pm25_mean <= m_data_reg.pm25_maximum))
        else $error("PM2.5 mean outside min/max");

endmodule
